// ----- rtl/core/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants of the aging priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 8;

  localparam logic [CFG_W-1:0] MAX_PRIO_RESET = 8'd255;

  typedef enum logic {
    KIND_INSERT   = 1'b0,
    KIND_RETRIEVE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_RETRIEVED = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BADPRIO   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_e;

  // control given to each cell of the chain: op is shared, last marks the final cell
  typedef struct packed {
    cell_op_e op;
    logic     last;
  } cell_ctl_t;

endpackage

// ----- rtl/core/apq_if.sv -----
// ----------------------------------------------------------------------------
// apq_if
// Request and response channels of the aging priority queue.
// ----------------------------------------------------------------------------
interface apq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [apq_pkg::ID_W-1:0]   item_id;
  logic [apq_pkg::PRIO_W-1:0] item_priority;

  modport source (output valid, kind, item_id, item_priority, input ready);
  modport sink   (input valid, kind, item_id, item_priority, output ready);
endinterface

interface apq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [apq_pkg::STATUS_W-1:0] status;
  logic [apq_pkg::ID_W-1:0]     head_id;
  logic [apq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, head_id, occupancy, input ready);
  modport sink   (input valid, status, head_id, occupancy, output ready);
endinterface

// ----- rtl/core/apq_cell.sv -----
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted chain: holds, takes the new pair, shifts from a
// neighbor and ages its priority on a pop.
// ----------------------------------------------------------------------------
module apq_cell #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                  clk_i,
  input  apq_pkg::cell_ctl_t    ctl_i,
  input  logic                  occupied_i,
  input  logic [ID_BITS-1:0]    new_id_i,
  input  logic [PRIO_BITS-1:0]  new_prio_i,
  input  logic [ID_BITS-1:0]    left_id_i,
  input  logic [PRIO_BITS-1:0]  left_prio_i,
  input  logic                  left_greater_i,
  input  logic [ID_BITS-1:0]    right_id_i,
  input  logic [PRIO_BITS-1:0]  right_prio_i,
  output logic [ID_BITS-1:0]    id_o,
  output logic [PRIO_BITS-1:0]  prio_o,
  output logic                  greater_o
);

  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [ID_BITS-1:0]   pop_id;
  logic [PRIO_BITS-1:0] pop_prio;

  // empty slots count as larger so the insert point is the first of them
  assign greater_o = !occupied_i || (prio_q > new_prio_i);

  // last cell keeps its own value on a pop
  assign pop_id   = ctl_i.last ? id_q : right_id_i;
  assign pop_prio = ctl_i.last ? prio_q : right_prio_i;

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    unique case (ctl_i.op)
      apq_pkg::CELL_PUSH: begin
        if (greater_o) begin
          if (left_greater_i) begin
            id_d   = left_id_i;
            prio_d = left_prio_i;
          end else begin
            id_d   = new_id_i;
            prio_d = new_prio_i;
          end
        end
      end
      apq_pkg::CELL_POP: begin
        id_d   = pop_id;
        prio_d = (pop_prio > PRIO_BITS'(1)) ? pop_prio - PRIO_BITS'(1) : pop_prio;
      end
      default: begin
        id_d   = id_q;
        prio_d = prio_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

// ----- rtl/core/aging_priority_queue.sv -----
// ----------------------------------------------------------------------------
// aging_priority_queue
// Timing: the response is registered and shows the cycle after its request
// is taken. Throughput: one request per cycle unless a response stalls, set
// by the chain that compares, shifts and ages all cells in the same cycle.
// Reset: count cleared, max priority set to 255, no response pending; slot
// contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module aging_priority_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [apq_pkg::CFG_W-1:0] cfg_wdata_i,
  apq_req_if.sink                   req_i,
  apq_rsp_if.source                 rsp_o
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (PRIO_BITS > apq_pkg::CFG_W) ? PRIO_BITS : apq_pkg::CFG_W;

  logic [apq_pkg::CFG_W-1:0] max_prio_q;
  logic [CW-1:0]             count_q, count_d;
  logic                      rsp_valid_q;
  apq_pkg::status_e          status_q, status_d;
  logic [ID_BITS-1:0]        head_q, head_d;
  logic [CW-1:0]             occ_q;

  logic                 req_fire;
  logic [ID_BITS-1:0]   new_id;
  logic [PRIO_BITS-1:0] new_prio;
  logic                 bad_prio;
  logic                 is_full;
  logic                 is_empty;
  apq_pkg::cell_op_e    cell_op;

  logic [ID_BITS-1:0]   cell_id   [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic                 cell_gt   [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  assign new_id   = ID_BITS'(req_i.item_id);
  assign new_prio = PRIO_BITS'(req_i.item_priority);
  assign bad_prio = (new_prio == '0) || (CMP_W'(new_prio) > CMP_W'(max_prio_q));
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    cell_op  = apq_pkg::CELL_HOLD;
    count_d  = count_q;
    status_d = apq_pkg::ST_EMPTY;
    head_d   = '0;
    if (req_i.kind == apq_pkg::KIND_INSERT) begin
      priority if (bad_prio) begin
        status_d = apq_pkg::ST_BADPRIO;
      end else if (is_full) begin
        status_d = apq_pkg::ST_FULL;
      end else begin
        status_d = apq_pkg::ST_INSERTED;
        cell_op  = apq_pkg::CELL_PUSH;
        count_d  = count_q + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = apq_pkg::ST_EMPTY;
      end else begin
        status_d = apq_pkg::ST_RETRIEVED;
        head_d   = cell_id[0];
        cell_op  = apq_pkg::CELL_POP;
        count_d  = count_q - CW'(1);
      end
    end
    if (!req_fire) begin
      cell_op = apq_pkg::CELL_HOLD;
      count_d = count_q;
    end
  end

  // cell chain, slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    apq_pkg::cell_ctl_t   ctl;
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic                 l_gt;

    assign ctl.op   = cell_op;
    assign ctl.last = (i == DEPTH - 1);

    if (i == 0) begin : g_first
      assign l_id   = new_id;
      assign l_prio = new_prio;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_gt   = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_id   = cell_id[i];
      assign r_prio = cell_prio[i];
    end else begin : g_inner
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    apq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .occupied_i     (count_q > CW'(i)),
      .new_id_i       (new_id),
      .new_prio_i     (new_prio),
      .left_id_i      (l_id),
      .left_prio_i    (l_prio),
      .left_greater_i (l_gt),
      .right_id_i     (r_id),
      .right_prio_i   (r_prio),
      .id_o           (cell_id[i]),
      .prio_o         (cell_prio[i]),
      .greater_o      (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_prio_q  <= apq_pkg::MAX_PRIO_RESET;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_prio_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q <= status_d;
      head_q   <= head_d;
      occ_q    <= count_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.head_id   = apq_pkg::ID_W'(head_q);
  assign rsp_o.occupancy = apq_pkg::OCC_W'(occ_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.kind == apq_pkg::KIND_RETRIEVE && !is_empty
    |=> count_q == $past(count_q) - CW'(1))
    else $error("retrieve did not remove one entry");

  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (status_d == apq_pkg::ST_BADPRIO || status_d == apq_pkg::ST_FULL)
    |=> count_q == $past(count_q))
    else $error("rejected insert changed the queue");

  a_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && status_q != apq_pkg::ST_RETRIEVED |-> head_q == '0)
    else $error("head id set on a non-retrieve response");

  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> occ_q == count_q)
    else $error("occupancy differs from entry count");
`endif

endmodule
